### design/gta_pkg.sv
package gta_pkg;

   // tanh table geometry: DEPTH+1 points over [0, 8]
   localparam int TANH_DEPTH     = 256;
   localparam int TANH_IDX_BITS  = $clog2(TANH_DEPTH);
   localparam int TANH_ADDR_BITS = TANH_IDX_BITS + 1;
   localparam int SPAN_SHIFT     = 3;

   // q0.31 constants
   localparam int          Q31_FRAC  = 31;
   localparam logic [26:0] FIT_Q31   = 27'd96024731;
   localparam logic [30:0] SQ2PI_Q31 = 31'd1713444089;
   localparam logic [63:0] Q31_ONE   = 64'h0000_0000_8000_0000;
   localparam logic [63:0] Q31_HALF  = 64'h0000_0000_4000_0000;

   // signed 32-bit limits of the intermediates, as magnitudes
   localparam logic [63:0] MID_MAX     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] MID_MIN_MAG = 64'h0000_0000_8000_0000;

   typedef logic [31:0] tanh_rom_type [0:TANH_DEPTH];

   // restoring long division, only ever evaluated at elaboration
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(8k/DEPTH) in q0.31 from powers of e^(-16/DEPTH)
   function automatic tanh_rom_type build_tanh_rom();
      tanh_rom_type rom;
      logic [63:0]  step;
      logic [63:0]  term;
      logic [63:0]  base;
      logic [63:0]  p;
      logic [63:0]  num;
      logic [63:0]  den;
      step = (64'd16 << Q31_FRAC) / TANH_DEPTH;
      term = Q31_ONE;
      base = Q31_ONE;
      p    = Q31_ONE;
      // taylor series of the exponential step
      for (int n = 1; n <= 20; n++) begin
         term = udiv((term * step + Q31_HALF) >> Q31_FRAC, 64'(n));
         if (n[0]) begin
            base = base - term;
         end else begin
            base = base + term;
         end
      end
      // tanh = (1 - p) / (1 + p), rounded
      for (int k = 0; k <= TANH_DEPTH; k++) begin
         num    = (Q31_ONE - p) * Q31_ONE;
         den    = Q31_ONE + p;
         rom[k] = 32'(udiv(num + (den >> 1), den));
         p      = (p * base + Q31_HALF) >> Q31_FRAC;
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();

endpackage

### design/gta_tanh.sv
module gta_tanh #(
   parameter int FRAC_BITS = 11
) (
   input  logic               clock,
   input  logic               pipe_en,
   input  logic [30:0]        u_mag,
   output logic [FRAC_BITS:0] t_mag
);

   localparam int SPAN_BITS = FRAC_BITS + gta_pkg::SPAN_SHIFT;
   localparam int PROD_WIDTH = 31 + SPAN_BITS;
   localparam int OUT_SHIFT = gta_pkg::Q31_FRAC - FRAC_BITS;
   localparam logic [63:0] SPAN_LIMIT = 64'd1 << SPAN_BITS;
   localparam logic [63:0] FRAC_HALF = 64'd1 << (SPAN_BITS - 1);
   localparam logic [63:0] OUT_HALF = 64'd1 << (OUT_SHIFT - 1);
   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [63:0]                          scaled;
   logic [gta_pkg::TANH_IDX_BITS-1:0]    idx;
   logic [gta_pkg::TANH_ADDR_BITS-1:0]   lo_addr;
   logic [gta_pkg::TANH_ADDR_BITS-1:0]   hi_addr;

   logic [31:0]            lo_in, lo_ff;
   logic [31:0]            hi_in, hi_ff;
   logic [SPAN_BITS-1:0]   frac_in, frac_ff;
   logic                   sat_in, sat_ff;
   logic [30:0]            diff_in, diff_ff;
   logic [31:0]            base2_ff;
   logic [SPAN_BITS-1:0]   frac2_ff;
   logic                   sat2_ff;
   logic [PROD_WIDTH-1:0]  prod_in, prod_ff;
   logic [31:0]            base3_ff;
   logic                   sat3_ff;
   logic [31:0]            q_in, q_ff;
   logic                   sat4_ff;
   logic [FRAC_BITS:0]     t_in, t_ff;

   // split the magnitude into table index and interpolation fraction
   always_comb begin
      scaled  = 64'(u_mag) << gta_pkg::TANH_IDX_BITS;
      idx     = gta_pkg::TANH_IDX_BITS'(scaled >> SPAN_BITS);
      lo_addr = gta_pkg::TANH_ADDR_BITS'(idx);
      hi_addr = lo_addr + gta_pkg::TANH_ADDR_BITS'(1);
      lo_in   = gta_pkg::TANH_ROM[lo_addr];
      hi_in   = gta_pkg::TANH_ROM[hi_addr];
      frac_in = SPAN_BITS'(scaled);
      sat_in  = 64'(u_mag) >= SPAN_LIMIT;
   end

   // slope between the two neighboring points, table is monotonic
   assign diff_in = 31'(hi_ff - lo_ff);

   // slope times fraction
   assign prod_in = PROD_WIDTH'(diff_ff) * PROD_WIDTH'(frac2_ff);

   // interpolated point in q0.31
   assign q_in = 32'(64'(base3_ff) + ((64'(prod_ff) + FRAC_HALF) >> SPAN_BITS));

   // back to the sample format, one beyond the span
   assign t_in = sat4_ff ? T_ONE : (FRAC_BITS + 1)'((64'(q_ff) + OUT_HALF) >> OUT_SHIFT);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         frac_ff  <= frac_in;
         sat_ff   <= sat_in;
         diff_ff  <= diff_in;
         base2_ff <= lo_ff;
         frac2_ff <= frac_ff;
         sat2_ff  <= sat_ff;
         prod_ff  <= prod_in;
         base3_ff <= base2_ff;
         sat3_ff  <= sat2_ff;
         q_ff     <= q_in;
         sat4_ff  <= sat3_ff;
         t_ff     <= t_in;
      end
   end

   assign t_mag = t_ff;

endmodule

### design/gelu_tanh_approx.sv
// tanh-approximated gelu, one sample in and one result out per transaction
// throughput: one transaction per cycle while the skid entry is empty, set by a
// 15-stage pipeline with one multiplier or one rounding adder per stage and
// the tanh table read in a single stage
// a one-entry skid register behind the output register absorbs a stalled result
// reset: synchronous, active high; clears all valid bits, no data is flushed out
module gelu_tanh_approx #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // x
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata   // y
);

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int PIPE_STAGES = 15;
   localparam int LAST = PIPE_STAGES - 1;
   localparam int SQ_WIDTH = 2 * DATA_WIDTH - 1;
   localparam int A0_WIDTH = 29;
   localparam int P2_WIDTH = A0_WIDTH + DATA_WIDTH;
   localparam int TP_WIDTH = FRAC_BITS + 2;
   localparam int P4_WIDTH = DATA_WIDTH + TP_WIDTH;
   localparam logic [63:0] F_HALF = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] Y_HALF = 64'd1 << FRAC_BITS;
   localparam logic [63:0] Y_MAX = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
   localparam logic [63:0] Y_MIN_MAG = 64'd1 << (DATA_WIDTH - 1);
   localparam logic [A0_WIDTH-1:0] A0_ONE = A0_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic [TP_WIDTH-1:0] TP_ONE = TP_WIDTH'(64'd1 << FRAC_BITS);

   // pipeline control
   logic                    pipe_en;
   logic [PIPE_STAGES-1:0]  pipe_v_in, pipe_v_ff;
   logic                    last_v;
   logic                    out_free;

   // sign and magnitude of x travel beside the datapath
   logic signed [DATA_WIDTH-1:0]     x_in;
   logic signed [2*DATA_WIDTH-1:0]   sq_full;
   logic [DATA_WIDTH:0]              side_in;
   logic [DATA_WIDTH:0]              side_ff [PIPE_STAGES];

   // datapath registers
   logic [SQ_WIDTH-1:0]   sq_in, sq_ff;
   logic [30:0]           m0_in, m0_ff;
   logic [57:0]           p1_in, p1_ff;
   logic [A0_WIDTH-1:0]   a0_in, a0_ff;
   logic [P2_WIDTH-1:0]   p2_in, p2_ff;
   logic [31:0]           m2_in, m2_ff;
   logic [62:0]           p3_in, p3_ff;
   logic [30:0]           umag_in, umag_ff;
   logic [FRAC_BITS:0]    t_mag;
   logic [TP_WIDTH-1:0]   tp_in, tp_ff;
   logic [P4_WIDTH-1:0]   p4_in, p4_ff;

   logic [63:0]            m0_rnd;
   logic [63:0]            m2_rnd;
   logic [63:0]            m2_lim;
   logic [63:0]            y_rnd;
   logic [63:0]            y_lim;
   logic [DATA_WIDTH-1:0]  y_mag;
   logic [DATA_WIDTH-1:0]  y_calc;

   // output register and skid entry
   logic                   rsp_tvalid_in, rsp_tvalid_ff;
   logic [DATA_WIDTH-1:0]  rsp_y_in, rsp_y_ff;
   logic                   skid_v_in, skid_v_ff;
   logic [DATA_WIDTH-1:0]  skid_y_in, skid_y_ff;

   // the pipeline moves whenever the skid entry is free
   assign pipe_en    = !skid_v_ff;
   assign req_tready = pipe_en;
   assign pipe_v_in  = {pipe_v_ff[PIPE_STAGES-2:0], req_tvalid};
   assign last_v     = pipe_v_ff[LAST];

   // stage 0: square and split x into sign and magnitude
   always_comb begin
      x_in    = req_tdata[DATA_WIDTH-1:0];
      sq_full = x_in * x_in;
      sq_in   = sq_full[SQ_WIDTH-1:0];
      side_in = {x_in[DATA_WIDTH-1], DATA_WIDTH'(x_in[DATA_WIDTH-1] ? -x_in : x_in)};
   end

   // stage 1: round and saturate x*x
   always_comb begin
      m0_rnd = (64'(sq_ff) + F_HALF) >> FRAC_BITS;
      m0_in  = (m0_rnd > gta_pkg::MID_MAX) ? 31'h7FFF_FFFF : m0_rnd[30:0];
   end

   // stage 2: times the cubic coefficient
   assign p1_in = 58'(m0_ff) * 58'(gta_pkg::FIT_Q31);

   // stage 3: round and add one
   assign a0_in = A0_WIDTH'(((64'(p1_ff) + gta_pkg::Q31_HALF) >> gta_pkg::Q31_FRAC)
                            + 64'(A0_ONE));

   // stage 4: times |x|
   assign p2_in = P2_WIDTH'(a0_ff) * P2_WIDTH'(side_ff[3][DATA_WIDTH-1:0]);

   // stage 5: round and saturate by the sign of x
   always_comb begin
      m2_rnd = (64'(p2_ff) + F_HALF) >> FRAC_BITS;
      m2_lim = side_ff[4][DATA_WIDTH] ? gta_pkg::MID_MIN_MAG : gta_pkg::MID_MAX;
      m2_in  = 32'((m2_rnd > m2_lim) ? m2_lim : m2_rnd);
   end

   // stage 6: times sqrt(2/pi)
   assign p3_in = 63'(m2_ff) * 63'(gta_pkg::SQ2PI_Q31);

   // stage 7: tanh argument magnitude
   assign umag_in = 31'((64'(p3_ff) + gta_pkg::Q31_HALF) >> gta_pkg::Q31_FRAC);

   // stages 8 to 12: table interpolation of tanh
   gta_tanh #(
      .FRAC_BITS (FRAC_BITS)
   ) u_tanh (
      .clock   (clock),
      .pipe_en (pipe_en),
      .u_mag   (umag_ff),
      .t_mag   (t_mag)
   );

   // stage 13: one plus tanh, tanh odd in x
   assign tp_in = side_ff[12][DATA_WIDTH] ? (TP_ONE - TP_WIDTH'(t_mag))
                                          : (TP_ONE + TP_WIDTH'(t_mag));

   // stage 14: |x| times (1 + tanh)
   assign p4_in = P4_WIDTH'(side_ff[13][DATA_WIDTH-1:0]) * P4_WIDTH'(tp_ff);

   // halve, round and saturate to the sample width
   always_comb begin
      y_rnd  = (64'(p4_ff) + Y_HALF) >> (FRAC_BITS + 1);
      y_lim  = side_ff[LAST][DATA_WIDTH] ? Y_MIN_MAG : Y_MAX;
      y_mag  = DATA_WIDTH'((y_rnd > y_lim) ? y_lim : y_rnd);
      y_calc = side_ff[LAST][DATA_WIDTH] ? -y_mag : y_mag;
   end

   // output register with skid entry behind it
   always_comb begin
      out_free      = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_y_in      = rsp_y_ff;
      skid_v_in     = skid_v_ff;
      skid_y_in     = skid_y_ff;
      if (out_free) begin
         if (skid_v_ff) begin
            rsp_tvalid_in = 1'b1;
            rsp_y_in      = skid_y_ff;
            skid_v_in     = 1'b0;
         end else begin
            rsp_tvalid_in = last_v;
            rsp_y_in      = y_calc;
         end
      end else if (last_v && !skid_v_ff) begin
         skid_v_in = 1'b1;
         skid_y_in = y_calc;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         skid_v_ff     <= 1'b0;
      end else begin
         if (pipe_en) begin
            pipe_v_ff <= pipe_v_in;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_v_ff     <= skid_v_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < PIPE_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         sq_ff   <= sq_in;
         m0_ff   <= m0_in;
         p1_ff   <= p1_in;
         a0_ff   <= a0_in;
         p2_ff   <= p2_in;
         m2_ff   <= m2_in;
         p3_ff   <= p3_in;
         umag_ff <= umag_in;
         tp_ff   <= tp_in;
         p4_ff   <= p4_in;
      end
      rsp_y_ff  <= rsp_y_in;
      skid_y_ff <= skid_y_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(rsp_y_ff);

`ifndef SYNTHESIS
   // the skid entry is only used behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_tvalid_ff)
      else $error("skid entry valid while output register empty");

   // a finished result meeting a stalled output lands in the skid entry
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready && !skid_v_ff && pipe_v_ff[LAST]) |=> skid_v_ff)
      else $error("finished result not captured in skid entry");

   // a full skid entry freezes the pipeline
   a_hold_on_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |=> $stable(pipe_v_ff))
      else $error("pipeline moved while skid entry full");

   // taking the output drains the skid entry into it
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_tready) |=> (rsp_tvalid_ff && !skid_v_ff))
      else $error("skid entry not moved to output register");

   // an accepted transaction enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> pipe_v_ff[0])
      else $error("accepted transaction missing from first stage");
`endif

endmodule

### verif/gelu_tanh_approx_test.sv
`timescale 1ns / 100ps

module gelu_tanh_approx_test;

   localparam int     DATA_W      = 16;
   localparam int     FRAC_W      = 11;
   localparam int     TANH_POINTS = 256;
   localparam longint UNIT        = 64'sd1 << FRAC_W;
   localparam longint Q31_UNIT    = 64'sd1 << 31;
   // 0.044715 and sqrt(2/pi) as unsigned q0.31
   localparam longint GAUSS_FIT   = 64'sd96024731;
   localparam longint TANH_GAIN   = 64'sd1713444089;
   // tanh argument where the table runs out, in q4.11
   localparam longint TANH_SPAN   = 64'sd1 << (FRAC_W + 3);

   typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} ready_mode_type;

   // expected gelu results, oldest first
   class gelu_checker_type;
      longint      tanh_points [0:TANH_POINTS];
      logic [15:0] expected_y [$];
      logic [15:0] sample_x [$];
      int          mismatches;

      function new();
         longint step, term, base, p, num, den;
         mismatches = 0;
         step = (64'sd16 << 31) / TANH_POINTS;
         term = Q31_UNIT;
         base = Q31_UNIT;
         p    = Q31_UNIT;
         // e^(-16/depth) from its taylor series
         for (int n = 1; n <= 20; n++) begin
            term = round_away(term * step, 31) / n;
            if (n % 2 == 1) begin
               base = base - term;
            end else begin
               base = base + term;
            end
         end
         // tanh(8k/depth) = (1 - p) / (1 + p) with p = e^(-16k/depth)
         for (int k = 0; k <= TANH_POINTS; k++) begin
            num = (Q31_UNIT - p) * Q31_UNIT;
            den = Q31_UNIT + p;
            tanh_points[k] = (num + den / 2) / den;
            p = round_away(p * base, 31);
         end
      endfunction

      // round to nearest, ties away from zero
      function longint round_away(longint v, int n);
         longint mag;
         mag = (v < 0) ? -v : v;
         mag = (mag + (64'sd1 << (n - 1))) >> n;
         return (v < 0) ? -mag : mag;
      endfunction

      function longint clamp_bits(longint v, int bits);
         longint hi;
         hi = (64'sd1 << (bits - 1)) - 1;
         if (v > hi) begin
            return hi;
         end
         if (v < -hi - 1) begin
            return -hi - 1;
         end
         return v;
      endfunction

      // sqrt(2/pi) * x * (1 + 0.044715 x^2), signed q20.11 held in 32 bits
      function longint tanh_arg(logic [15:0] x_raw);
         longint x, sq, cub, sum, prod;
         x    = longint'($signed(x_raw));
         sq   = clamp_bits(round_away(x * x, FRAC_W), 32);
         cub  = clamp_bits(round_away(sq * GAUSS_FIT, 31), 32);
         sum  = clamp_bits(cub + UNIT, 32);
         prod = clamp_bits(round_away(sum * x, FRAC_W), 32);
         return clamp_bits(round_away(prod * TANH_GAIN, 31), 32);
      endfunction

      function logic [15:0] gelu_q(logic [15:0] x_raw);
         longint x, u, mag, scaled, idx, frac, lo, hi, q, t, y;
         x   = longint'($signed(x_raw));
         u   = tanh_arg(x_raw);
         mag = (u < 0) ? -u : u;
         // tanh saturates beyond the table, else interpolate between points
         if (mag >= TANH_SPAN) begin
            t = UNIT;
         end else begin
            scaled = mag * TANH_POINTS;
            idx    = scaled >> (FRAC_W + 3);
            frac   = scaled & (TANH_SPAN - 1);
            if (idx > TANH_POINTS - 1) begin
               idx = TANH_POINTS - 1;
            end
            lo = tanh_points[idx];
            hi = tanh_points[idx + 1];
            q  = lo + round_away((hi - lo) * frac, FRAC_W + 3);
            t  = round_away(q, 31 - FRAC_W);
         end
         if (u < 0) begin
            t = -t;
         end
         // x * (1 + t) / 2, one rounding
         y = clamp_bits(round_away(x * (t + UNIT), FRAC_W + 1), DATA_W);
         return 16'(y);
      endfunction

      function void note_sample(logic [15:0] x);
         expected_y.push_back(gelu_q(x));
         sample_x.push_back(x);
      endfunction

      function void check_result(logic [15:0] y);
         logic [15:0] want;
         logic [15:0] x;
         if (expected_y.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result y=%0d with no sample outstanding", $signed(y));
            end
            return;
         end
         want = expected_y.pop_front();
         x    = sample_x.pop_front();
         if (y !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch for x=%0d: expected y=%0d, got y=%0d",
                        $signed(x), $signed(want), $signed(y));
            end
         end
      endfunction

      function int pending();
         return expected_y.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // x
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // y

   gelu_checker_type sb         = new;
   int               burst_left = 0;
   ready_mode_type   rx_mode    = RX_ALWAYS;
   int               rx_hold    = 0;
   int               rx_phase   = 0;

   gelu_tanh_approx u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // run limit
   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   // receiver stalls, switching between patterns now and then
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_mode <= ready_mode_type'($urandom_range(0, 3));
         rx_hold <= $urandom_range(40, 200);
      end else begin
         rx_hold <= rx_hold - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_mode)
         RX_ALWAYS:  rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= ($urandom_range(0, 1) == 1);
         RX_PATTERN: rsp_tready <= (rx_phase % 5 < 3);
         default:    rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // watch both channels for completed transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
      end
   end

   // present one sample, in bursts with random gaps, until it is taken
   task automatic issue_sample(input logic [15:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 3);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) begin
               req_tdata <= 16'($urandom);
               @(posedge clock);
            end
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [15:0] directed [$];
      logic [15:0] x;
      int          sat_start;
      int          guard;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // smallest input whose tanh argument leaves the table
      sat_start = 8192;
      while (sb.tanh_arg(16'(sat_start)) < TANH_SPAN) begin
         sat_start++;
      end

      // extremes, unit steps and the tanh saturation boundary
      directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0002, 16'h7FFF, 16'h8000, 16'h8001,
                   16'h0800, 16'hF800, 16'h0400, 16'hFC00, 16'h1000, 16'hF000,
                   16'h2000, 16'hE000, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA};
      directed.push_back(16'(sat_start - 1));
      directed.push_back(16'(sat_start));
      directed.push_back(16'(-(sat_start - 1)));
      directed.push_back(16'(-sat_start));
      foreach (directed[i]) begin
         issue_sample(directed[i]);
      end

      // random samples, weighted toward the curved part of the function
      repeat (1300) begin
         case ($urandom_range(0, 4))
            0, 1: x = 16'($urandom);
            2, 3: x = 16'($urandom_range(0, 12288));
            default: x = 16'($urandom_range(0, 2048));
         endcase
         if ($urandom_range(0, 1) == 1) begin
            x = -x;
         end
         issue_sample(x);
      end
      req_tvalid <= 1'b0;

      // drain, then allow for the pipeline depth
      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
